[rtl/core/thal_pkg.sv]
// ----------------------------------------------------------------------------
// Threshold alert hysteresis package
// Shared widths, codes and structures of the threshold alert hysteresis unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thal_pkg;

  localparam int unsigned ValW     = 64;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [ValW-1:0]  LowThrRst  = '0;
  localparam logic [ValW-1:0]  HighThrRst = '1;
  localparam logic [TimeW-1:0] PersistRst = '0;

  typedef enum logic [KindW-1:0] {
    KindRaise    = 2'd0,
    KindContinue = 2'd1,
    KindFall     = 2'd2
  } alert_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLowThr  = 2'd0,
    CfgHighThr = 2'd1,
    CfgPersist = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ValW-1:0]  low_thr;
    logic [ValW-1:0]  high_thr;
    logic [TimeW-1:0] persist;
  } cfg_t;

  typedef struct packed {
    logic [ValW-1:0]  smp_value;
    logic [TimeW-1:0] smp_time;
  } item_t;

  typedef struct packed {
    logic        emit;
    alert_kind_e kind;
  } alert_t;

endpackage

`default_nettype wire

[rtl/core/thal_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Threshold alert configuration registers
// Holds the low and high thresholds and the persistence time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thal_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [thal_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [thal_pkg::CfgDataW-1:0] cfg_data_i,
  output thal_pkg::cfg_t                     cfg_o
);

  thal_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (thal_pkg::cfg_idx_e'(cfg_idx_i))
        thal_pkg::CfgLowThr:  cfg_d.low_thr  = cfg_data_i[thal_pkg::ValW-1:0];
        thal_pkg::CfgHighThr: cfg_d.high_thr = cfg_data_i[thal_pkg::ValW-1:0];
        thal_pkg::CfgPersist: cfg_d.persist  = cfg_data_i[thal_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr  <= thal_pkg::LowThrRst;
      cfg_q.high_thr <= thal_pkg::HighThrRst;
      cfg_q.persist  <= thal_pkg::PersistRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/thal_in_stage.sv]
// ----------------------------------------------------------------------------
// Threshold alert input stage
// Registers one sample and holds it until the decision stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thal_in_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [thal_pkg::ValW-1:0]  sample_value_i,
  input  wire logic [thal_pkg::TimeW-1:0] sample_time_i,
  input  wire logic                       take_i,
  output logic                            item_valid_o,
  output thal_pkg::item_t                 item_o
);

  logic            valid_q, valid_d;
  thal_pkg::item_t item_q;
  logic            load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.smp_value <= sample_value_i;
      item_q.smp_time  <= sample_time_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

[rtl/core/thal_alert_ctrl.sv]
// ----------------------------------------------------------------------------
// Threshold alert controller
// Holds the alert state and the persistence marks and decides on each sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thal_alert_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  thal_pkg::cfg_t  cfg_i,
  input  thal_pkg::item_t item_i,
  input  wire logic       fire_i,
  output thal_pkg::alert_t alert_o
);

  logic                       active_q, active_d;
  logic [thal_pkg::TimeW-1:0] hi_mark_q, hi_mark_d;
  logic                       hi_valid_q, hi_valid_d;
  logic [thal_pkg::TimeW-1:0] lo_mark_q, lo_mark_d;
  logic                       lo_valid_q, lo_valid_d;
  logic [thal_pkg::TimeW-1:0] hi_diff, lo_diff;
  logic                       hi_elapsed, lo_elapsed, persist_zero;
  thal_pkg::alert_t           alert;

  assign hi_diff      = item_i.smp_time - hi_mark_q;
  assign lo_diff      = item_i.smp_time - lo_mark_q;
  assign hi_elapsed   = (item_i.smp_time >= hi_mark_q) && (hi_diff >= cfg_i.persist);
  assign lo_elapsed   = (item_i.smp_time >= lo_mark_q) && (lo_diff >= cfg_i.persist);
  assign persist_zero = (cfg_i.persist == '0);

  always_comb begin
    active_d   = active_q;
    hi_mark_d  = hi_mark_q;
    hi_valid_d = hi_valid_q;
    lo_mark_d  = lo_mark_q;
    lo_valid_d = lo_valid_q;
    alert.emit = 1'b0;
    alert.kind = thal_pkg::KindRaise;
    if (!active_q) begin
      if (item_i.smp_value >= cfg_i.high_thr) begin
        hi_valid_d = 1'b1;
        if (!hi_valid_q) begin
          hi_mark_d = item_i.smp_time;
        end
        // A fresh mark equals the sample time, so only a zero hold time passes.
        if (hi_valid_q ? hi_elapsed : persist_zero) begin
          active_d   = 1'b1;
          hi_mark_d  = item_i.smp_time;
          lo_valid_d = 1'b0;
          lo_mark_d  = '0;
          alert.emit = 1'b1;
          alert.kind = thal_pkg::KindRaise;
        end
      end else begin
        hi_valid_d = 1'b0;
        hi_mark_d  = '0;
      end
    end else if (item_i.smp_value >= cfg_i.low_thr) begin
      lo_valid_d = 1'b0;
      lo_mark_d  = '0;
      if (hi_elapsed) begin
        hi_mark_d  = item_i.smp_time;
        hi_valid_d = 1'b1;
        alert.emit = 1'b1;
        alert.kind = thal_pkg::KindContinue;
      end
    end else if (!lo_valid_q) begin
      lo_mark_d  = item_i.smp_time;
      lo_valid_d = 1'b1;
    end else if (lo_elapsed) begin
      active_d   = 1'b0;
      lo_mark_d  = item_i.smp_time;
      hi_valid_d = 1'b0;
      hi_mark_d  = '0;
      alert.emit = 1'b1;
      alert.kind = thal_pkg::KindFall;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      hi_mark_q  <= '0;
      hi_valid_q <= 1'b0;
      lo_mark_q  <= '0;
      lo_valid_q <= 1'b0;
    end else if (fire_i) begin
      active_q   <= active_d;
      hi_mark_q  <= hi_mark_d;
      hi_valid_q <= hi_valid_d;
      lo_mark_q  <= lo_mark_d;
      lo_valid_q <= lo_valid_d;
    end
  end

  assign alert_o = alert;

endmodule

`default_nettype wire

[rtl/core/thal_out_stage.sv]
// ----------------------------------------------------------------------------
// Threshold alert output stage
// Registers one alert and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thal_out_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  thal_pkg::alert_t                 alert_i,
  input  thal_pkg::item_t                  item_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [thal_pkg::KindW-1:0]       alert_kind_o,
  output logic [thal_pkg::ValW-1:0]        alert_value_o,
  output logic [thal_pkg::TimeW-1:0]       alert_time_o
);

  logic                       valid_q, valid_d;
  thal_pkg::alert_kind_e      kind_q;
  logic [thal_pkg::ValW-1:0]  value_q;
  logic [thal_pkg::TimeW-1:0] time_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q  <= alert_i.kind;
      value_q <= item_i.smp_value;
      time_q  <= item_i.smp_time;
    end
  end

  assign out_valid_o   = valid_q;
  assign alert_kind_o  = kind_q;
  assign alert_value_o = value_q;
  assign alert_time_o  = time_q;

endmodule

`default_nettype wire

[rtl/core/threshold_alert_hysteresis_unit.sv]
// ----------------------------------------------------------------------------
// Threshold alert hysteresis unit
// Watches timestamped samples against two thresholds with a persistence timer
// and reports raise, continue and fall alerts.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  cfg       in         cfg_we_i               cfg_idx_i, cfg_data_i
//  sample    in         in_valid_i/in_stall_o  sample_value_i, sample_time_i
//  alert     out        out_valid_o/out_stall_i alert_kind_o, alert_value_o,
//                                              alert_time_o
//
// One sample enters per cycle while in_stall_o is low; each alert is loaded
// from the sample register via the decision logic into the alert register,
// so the state update of one sample is ready for the next.
// Reset restores the register defaults and returns the unit to idle.
// A stalled alert holds the output; one more sample then waits in its register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module threshold_alert_hysteresis_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [thal_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [thal_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [thal_pkg::ValW-1:0]     sample_value_i,
  input  wire logic [thal_pkg::TimeW-1:0]    sample_time_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [thal_pkg::KindW-1:0]         alert_kind_o,
  output logic [thal_pkg::ValW-1:0]          alert_value_o,
  output logic [thal_pkg::TimeW-1:0]         alert_time_o
);

  thal_pkg::cfg_t   cfg;
  thal_pkg::item_t  item;
  thal_pkg::alert_t alert;
  logic             item_valid;
  logic             out_ready;
  logic             fire;

  assign fire = item_valid && out_ready;

  thal_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  thal_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .sample_time_i  (sample_time_i),
    .take_i         (fire),
    .item_valid_o   (item_valid),
    .item_o         (item)
  );

  thal_alert_ctrl u_alert_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .item_i  (item),
    .fire_i  (fire),
    .alert_o (alert)
  );

  thal_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire && alert.emit),
    .alert_i       (alert),
    .item_i        (item),
    .ready_o       (out_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .alert_kind_o  (alert_kind_o),
    .alert_value_o (alert_value_o),
    .alert_time_o  (alert_time_o)
  );

endmodule

`default_nettype wire
